### sv/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int W        = 32;          // part width, signed fixed point
  localparam int F        = 16;          // fractional bits
  localparam int QB       = W + 1;       // quotient bits kept by the divider
  localparam int MB       = 2 * W;       // numerator magnitude bits before shift

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;
  localparam logic [2:0] ACT_EQ  = 3'd5;

  typedef struct packed {
    logic [2:0]          action;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic                is_equal;
    logic                div_zero;
    logic                saturated;
  } rsp_t;

  // Sideband that rides along the pipeline with each beat.
  typedef struct packed {
    logic [2:0]   action;
    logic [W-1:0] res_re;
    logic [W-1:0] res_im;
    logic         is_equal;
    logic         sat;
    logic         neg_re;
    logic         neg_im;
    logic         ov_re;
    logic         ov_im;
    logic         dz;
  } side_t;

  // Clip a 66-bit signed value to W bits; MSB of the result is the clip flag.
  function automatic logic [W:0] sat66(input logic signed [65:0] v);
    logic hi_same;
    hi_same = (v[65:W-1] == '0) || (v[65:W-1] == '1);
    if (hi_same) return {1'b0, v[W-1:0]};
    return v[65] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
  endfunction

endpackage

### sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, negate and compare on Q16.16 parts.
// ----------------------------------------------------------------------------
// One beat enters per cycle and one result beat leaves per cycle unless a
// stall freezes the pipeline; every beat passes 37 register stages whatever
// its action. The depth is set by the divider: two front stages (products,
// then combine), a range check stage, 33 restoring steps with one quotient
// bit per stage, and the output register. A stall on the result side
// freezes the whole pipeline, so req_stall follows rsp_stall whenever a
// result is held. Divide by a zero magnitude returns zero parts with div_zero
// set; quotients, products, sums and negations are clipped and flag saturated.
module complex_arithmetic_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cau_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cau_pkg::rsp_t  rsp
);
  import cau_pkg::*;

  logic          adv;
  logic          f_vld, d_vld;
  side_t         f_side, d_side;
  logic [MB-1:0] den, mag_re, mag_im;
  logic [QB-1:0] q_re, q_im;
  rsp_t          rsp_next;

  // Advance everything unless a finished result is being held.
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  cau_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(req_valid), .req(req),
    .vld(f_vld), .side(f_side), .den(den), .mag_re(mag_re), .mag_im(mag_im)
  );

  cau_div_pipe u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(f_vld), .in_side(f_side),
    .den(den), .mag_re(mag_re), .mag_im(mag_im),
    .vld(d_vld), .side(d_side), .q_re(q_re), .q_im(q_im)
  );

  // Sign and clip the quotients, then pick the result by action.
  localparam logic [QB-1:0] POS_MAX = QB'({1'b0, {(W-1){1'b1}}});
  localparam logic [QB-1:0] NEG_MAX = QB'({1'b1, {(W-1){1'b0}}});

  logic          c_re, c_im;
  logic [W-1:0]  v_re, v_im;

  always_comb begin
    c_re = d_side.ov_re || (d_side.neg_re ? (q_re > NEG_MAX) : (q_re > POS_MAX));
    c_im = d_side.ov_im || (d_side.neg_im ? (q_im > NEG_MAX) : (q_im > POS_MAX));
    v_re = d_side.neg_re ? W'(-q_re) : q_re[W-1:0];
    v_im = d_side.neg_im ? W'(-q_im) : q_im[W-1:0];
    if (c_re) v_re = d_side.neg_re ? NEG_MAX[W-1:0] : POS_MAX[W-1:0];
    if (c_im) v_im = d_side.neg_im ? NEG_MAX[W-1:0] : POS_MAX[W-1:0];

    rsp_next          = '0;
    rsp_next.is_equal = d_side.is_equal;
    case (d_side.action)
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_NEG: begin
        rsp_next.res_re    = d_side.res_re;
        rsp_next.res_im    = d_side.res_im;
        rsp_next.saturated = d_side.sat;
      end
      ACT_DIV: begin
        if (d_side.dz) begin
          rsp_next.div_zero = 1'b1;
        end else begin
          rsp_next.res_re    = v_re;
          rsp_next.res_im    = v_im;
          rsp_next.saturated = c_re | c_im;
        end
      end
      default: begin
        rsp_next.res_re = '0;
      end
    endcase
  end

  // Output register: hold the beat while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_zero |-> rsp.res_re == '0 && rsp.res_im == '0 && !rsp.saturated)
    else $error("div_zero result not zero");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_equal |-> !rsp.div_zero && !rsp.saturated)
    else $error("equality beat carries other flags");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a held result");

endmodule

### sv/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Product stage and combine stage: simple ops, multiply results, divide
// numerators and divisor.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  cau_pkg::req_t        req,
  output logic                 vld,
  output cau_pkg::side_t       side,
  output logic [2*cau_pkg::W-1:0] den,
  output logic [2*cau_pkg::W-1:0] mag_re,
  output logic [2*cau_pkg::W-1:0] mag_im
);
  import cau_pkg::*;

  // product stage
  logic                    b_vld;
  logic [2:0]              b_act;
  logic signed [2*W-1:0]   p_rr, p_ii, p_ri, p_ir, q_rr, q_ii;
  logic [W-1:0]            b_re, b_im;
  logic                    b_eq, b_sat;

  logic signed [W:0]       s_re, s_im;
  logic [W:0]              t_re, t_im;

  always_comb begin
    case (req.action)
      ACT_ADD: begin
        s_re = {req.a_re[W-1], req.a_re} + {req.b_re[W-1], req.b_re};
        s_im = {req.a_im[W-1], req.a_im} + {req.b_im[W-1], req.b_im};
      end
      ACT_SUB: begin
        s_re = {req.a_re[W-1], req.a_re} - {req.b_re[W-1], req.b_re};
        s_im = {req.a_im[W-1], req.a_im} - {req.b_im[W-1], req.b_im};
      end
      ACT_NEG: begin
        s_re = -{req.a_re[W-1], req.a_re};
        s_im = -{req.a_im[W-1], req.a_im};
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    t_re = sat66({{(66-W-1){s_re[W]}}, s_re});
    t_im = sat66({{(66-W-1){s_im[W]}}, s_im});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_act <= req.action;
      p_rr  <= req.a_re * req.b_re;
      p_ii  <= req.a_im * req.b_im;
      p_ri  <= req.a_re * req.b_im;
      p_ir  <= req.a_im * req.b_re;
      q_rr  <= req.b_re * req.b_re;
      q_ii  <= req.b_im * req.b_im;
      b_re  <= t_re[W-1:0];
      b_im  <= t_im[W-1:0];
      b_sat <= t_re[W] | t_im[W];
      b_eq  <= (req.action == ACT_EQ) && (req.a_re == req.b_re) && (req.a_im == req.b_im);
    end
  end

  // combine stage
  logic signed [65:0] m_re_w, m_im_w, nr, ni;
  logic [W:0]         m_re, m_im;
  side_t              side_next;

  always_comb begin
    m_re_w = ($signed({{2{p_rr[2*W-1]}}, p_rr}) - $signed({{2{p_ii[2*W-1]}}, p_ii})) >>> F;
    m_im_w = ($signed({{2{p_ri[2*W-1]}}, p_ri}) + $signed({{2{p_ir[2*W-1]}}, p_ir})) >>> F;
    m_re   = sat66(m_re_w);
    m_im   = sat66(m_im_w);
    nr     = $signed({{2{p_rr[2*W-1]}}, p_rr}) + $signed({{2{p_ii[2*W-1]}}, p_ii});
    ni     = $signed({{2{p_ir[2*W-1]}}, p_ir}) - $signed({{2{p_ri[2*W-1]}}, p_ri});
    side_next          = '0;
    side_next.action   = b_act;
    side_next.is_equal = b_eq;
    side_next.neg_re   = nr[65];
    side_next.neg_im   = ni[65];
    if (b_act == ACT_MUL) begin
      side_next.res_re = m_re[W-1:0];
      side_next.res_im = m_im[W-1:0];
      side_next.sat    = m_re[W] | m_im[W];
    end else begin
      side_next.res_re = b_re;
      side_next.res_im = b_im;
      side_next.sat    = b_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side   <= side_next;
      den    <= q_rr[2*W-1:0] + q_ii[2*W-1:0];
      mag_re <= nr[65] ? MB'(-nr) : nr[2*W-1:0];
      mag_im <= ni[65] ? MB'(-ni) : ni[2*W-1:0];
    end
  end

endmodule

### sv/cau_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_pipe
// Range check stage, then one restoring divide step per stage for both lanes.
// ----------------------------------------------------------------------------
module cau_div_pipe (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_vld,
  input  cau_pkg::side_t          in_side,
  input  logic [2*cau_pkg::W-1:0] den,
  input  logic [2*cau_pkg::W-1:0] mag_re,
  input  logic [2*cau_pkg::W-1:0] mag_im,
  output logic                    vld,
  output cau_pkg::side_t          side,
  output logic [cau_pkg::QB-1:0]  q_re,
  output logic [cau_pkg::QB-1:0]  q_im
);
  import cau_pkg::*;

  localparam int HB = MB + F - QB; // bits above the kept quotient

  logic          v   [0:QB];
  side_t         sd  [0:QB];
  logic [MB-1:0] dn  [0:QB];
  logic [MB-1:0] r_re[0:QB];
  logic [MB-1:0] r_im[0:QB];
  logic [QB-1:0] l_re[0:QB];
  logic [QB-1:0] l_im[0:QB];

  logic [MB+F-1:0] sh_re, sh_im;
  side_t           side0;

  always_comb begin
    sh_re = {mag_re, {F{1'b0}}};
    sh_im = {mag_im, {F{1'b0}}};
    side0 = in_side;
    side0.dz    = (den == '0);
    side0.ov_re = {{(MB-HB){1'b0}}, sh_re[MB+F-1:QB]} >= den;
    side0.ov_im = {{(MB-HB){1'b0}}, sh_im[MB+F-1:QB]} >= den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0]   <= side0;
      dn[0]   <= den;
      r_re[0] <= {{(MB-HB){1'b0}}, sh_re[MB+F-1:QB]};
      r_im[0] <= {{(MB-HB){1'b0}}, sh_im[MB+F-1:QB]};
      l_re[0] <= sh_re[QB-1:0];
      l_im[0] <= sh_im[QB-1:0];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [MB:0]   t_re, t_im;
    logic          ge_re, ge_im;
    logic [MB-1:0] rn_re, rn_im;

    always_comb begin
      t_re  = {r_re[k], l_re[k][QB-1]};
      t_im  = {r_im[k], l_im[k][QB-1]};
      ge_re = t_re >= {1'b0, dn[k]};
      ge_im = t_im >= {1'b0, dn[k]};
      rn_re = ge_re ? MB'(t_re - {1'b0, dn[k]}) : t_re[MB-1:0];
      rn_im = ge_im ? MB'(t_im - {1'b0, dn[k]}) : t_im[MB-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k+1]   <= sd[k];
        dn[k+1]   <= dn[k];
        r_re[k+1] <= rn_re;
        r_im[k+1] <= rn_im;
        l_re[k+1] <= {l_re[k][QB-2:0], ge_re};
        l_im[k+1] <= {l_im[k][QB-2:0], ge_im};
      end
    end
  end

  assign vld  = v[QB];
  assign side = sd[QB];
  assign q_re = l_re[QB];
  assign q_im = l_im[QB];

endmodule
